// File: rtl/kwh_pkg.sv
// ============================================================================
// kwh_pkg
// Shared types, codes and the entry ordering for the k-way merge min-heap.
// ============================================================================
package kwh_pkg;

    localparam int DEFAULT_HEAP_DEPTH = 16;
    localparam int VALUE_W            = 32;
    localparam int LANE_W             = 4;
    localparam int OCC_W              = 5;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [LANE_W-1:0]  lane;
    } entry_t;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_POP    = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_POP_RD,
        S_DN_RD,
        S_DN_CMP,
        S_RESP
    } state_t;

    // Result handed from the sequencer to the output stage.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [LANE_W-1:0]  lane;
        status_t            status;
        logic [OCC_W-1:0]   occupancy;
    } result_t;

    // Heap order: signed value first, then the lower lane leaves first.
    function automatic logic entry_less(input entry_t a, input entry_t b);
        logic v_lt;
        logic v_eq;
        v_lt = $signed(a.value) < $signed(b.value);
        v_eq = a.value == b.value;
        return v_lt || (v_eq && (a.lane < b.lane));
    endfunction

endpackage

// File: rtl/kwh_heap_mem.sv
// ============================================================================
// kwh_heap_mem
// Heap entry store: one write port and two registered read ports.
// ============================================================================
module kwh_heap_mem
    import kwh_pkg::*;
#(
    parameter int DEPTH = DEFAULT_HEAP_DEPTH,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic            clk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  entry_t          wdata,
    input  logic [AW-1:0]   raddr_a,
    input  logic [AW-1:0]   raddr_b,
    output entry_t          rdata_a,
    output entry_t          rdata_b
);

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// File: rtl/kwh_ctrl.sv
// ============================================================================
// kwh_ctrl
// Heap sequencer: takes one operation at a time and sifts the moving entry
// through the store one level per pass through the read and compare states.
// ============================================================================
module kwh_ctrl
    import kwh_pkg::*;
#(
    parameter int HEAP_DEPTH = DEFAULT_HEAP_DEPTH,
    parameter int AW         = $clog2(HEAP_DEPTH),
    parameter int CW         = $clog2(HEAP_DEPTH + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    // Operation side.
    input  logic          op_valid,
    output logic          op_ready,
    input  op_t           op,
    input  entry_t        op_entry,
    // Result side.
    output logic          res_valid,
    input  logic          res_ready,
    output result_t       res,
    // Store side.
    output logic          mem_we,
    output logic [AW-1:0] mem_waddr,
    output entry_t        mem_wdata,
    output logic [AW-1:0] mem_raddr_a,
    output logic [AW-1:0] mem_raddr_b,
    input  entry_t        mem_rdata_a,
    input  entry_t        mem_rdata_b
);

    localparam int XW = AW + 2;

    state_t             state_reg,  state_next;
    logic [CW-1:0]      count_reg,  count_next;
    logic [AW-1:0]      pos_reg,    pos_next;
    entry_t             mov_reg,    mov_next;
    logic [VALUE_W-1:0] rvalue_reg, rvalue_next;
    logic [LANE_W-1:0]  rlane_reg,  rlane_next;
    status_t            rstat_reg,  rstat_next;

    logic [XW-1:0] left_idx;
    logic [XW-1:0] right_idx;
    logic [XW-1:0] count_ext;
    logic [AW-1:0] parent_idx;
    logic          left_ok;
    logic          right_ok;
    logic          pick_right;
    entry_t        child;
    logic [AW-1:0] child_idx;

    assign left_idx   = (XW'(pos_reg) << 1) + XW'(1);
    assign right_idx  = left_idx + XW'(1);
    assign count_ext  = XW'(count_reg);
    assign parent_idx = (pos_reg - AW'(1)) >> 1;
    assign left_ok    = left_idx < count_ext;
    assign right_ok   = right_idx < count_ext;
    assign pick_right = right_ok && entry_less(mem_rdata_b, mem_rdata_a);
    assign child      = pick_right ? mem_rdata_b : mem_rdata_a;
    assign child_idx  = pick_right ? right_idx[AW-1:0] : left_idx[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        mov_reg    <= mov_next;
        rvalue_reg <= rvalue_next;
        rlane_reg  <= rlane_next;
        rstat_reg  <= rstat_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        mov_next    = mov_reg;
        rvalue_next = rvalue_reg;
        rlane_next  = rlane_reg;
        rstat_next  = rstat_reg;
        op_ready    = 1'b0;
        res_valid   = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = pos_reg;
        mem_wdata   = mov_reg;
        mem_raddr_a = '0;
        mem_raddr_b = AW'(count_reg - CW'(1));

        unique case (state_reg)
            S_IDLE:
            begin
                op_ready = 1'b1;
                if (op_valid)
                begin
                    rvalue_next = '0;
                    rlane_next  = '0;
                    rstat_next  = STATUS_DONE;
                    if (op == OP_INSERT)
                    begin
                        if (count_reg >= CW'(HEAP_DEPTH))
                        begin
                            rstat_next = STATUS_FULL;
                            state_next = S_RESP;
                        end
                        else
                        begin
                            mov_next   = op_entry;
                            pos_next   = AW'(count_reg);
                            count_next = count_reg + CW'(1);
                            state_next = S_UP_RD;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            rstat_next = STATUS_EMPTY;
                            state_next = S_RESP;
                        end
                        else
                        begin
                            // Root and last entry are read on the two ports.
                            count_next = count_reg - CW'(1);
                            state_next = S_POP_RD;
                        end
                    end
                end
            end

            S_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    mem_we     = 1'b1;
                    state_next = S_RESP;
                end
                else
                begin
                    mem_raddr_a = parent_idx;
                    state_next  = S_UP_CMP;
                end
            end

            S_UP_CMP:
            begin
                mem_we = 1'b1;
                if (entry_less(mov_reg, mem_rdata_a))
                begin
                    // Parent moves down into the hole.
                    mem_wdata  = mem_rdata_a;
                    pos_next   = parent_idx;
                    state_next = S_UP_RD;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end

            S_POP_RD:
            begin
                rvalue_next = mem_rdata_a.value;
                rlane_next  = mem_rdata_a.lane;
                mov_next    = mem_rdata_b;
                pos_next    = '0;
                state_next  = S_DN_RD;
            end

            S_DN_RD:
            begin
                mem_raddr_a = left_idx[AW-1:0];
                mem_raddr_b = right_idx[AW-1:0];
                state_next  = S_DN_CMP;
            end

            S_DN_CMP:
            begin
                mem_we = 1'b1;
                if (left_ok && entry_less(child, mov_reg))
                begin
                    // Smaller child moves up into the hole.
                    mem_wdata  = child;
                    pos_next   = child_idx;
                    state_next = S_DN_RD;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end

            S_RESP:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res.value     = rvalue_reg;
    assign res.lane      = rlane_reg;
    assign res.status    = rstat_reg;
    assign res.occupancy = OCC_W'(count_reg);

endmodule

// File: rtl/kway_merge_min_heap.sv
// ============================================================================
// kway_merge_min_heap
// Binary min-heap of (value, lane) entries for merging sorted streams.
// ============================================================================
// Each input word is an insert or a pop and gives exactly one output word.
// Entries order by signed value, with the lower lane first on equal values.
// Operations run one at a time. Each heap level that the moving entry
// crosses (at most log2(HEAP_DEPTH) levels) needs a read state and a
// compare-and-write state on the entry memory; a pop spends one more step
// reading the root and the last entry, and both kinds end with a read and
// compare that finds no further move unless an insert reaches the root.
// A pop on an empty heap or an insert on a full heap finishes with an
// error status and no change. The output word sits in a register and
// shows up on the master side in the cycle after the hand-off, so the next
// input word is taken while a result still waits on the master side; the
// sequencer only stalls when a finished result finds that register still
// holding an unsent word. The entry memory needs no clearing after reset;
// only entries below the occupancy count are ever used.
// ============================================================================
module kway_merge_min_heap
    import kwh_pkg::*;
#(
    parameter int HEAP_DEPTH = DEFAULT_HEAP_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // value[31:0], lane[35:32], zero pad
    input  logic [0:0]  s_tuser,   // op (0 insert, 1 pop)
    // Output stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // out_value[31:0], out_lane[35:32],
                                   // occupancy[40:36], zero pad
    output logic [1:0]  m_tuser    // status
);

    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int CW = $clog2(HEAP_DEPTH + 1);

    entry_t        op_entry;
    op_t           op;
    logic          res_valid;
    logic          res_ready;
    result_t       res;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    entry_t        mem_wdata;
    logic [AW-1:0] mem_raddr_a;
    logic [AW-1:0] mem_raddr_b;
    entry_t        mem_rdata_a;
    entry_t        mem_rdata_b;

    logic          m_tvalid_reg, m_tvalid_next;
    logic [47:0]   m_tdata_reg,  m_tdata_next;
    logic [1:0]    m_tuser_reg,  m_tuser_next;

    assign op_entry.value = s_tdata[31:0];
    assign op_entry.lane  = s_tdata[35:32];
    assign op             = op_t'(s_tuser[0]);

    kwh_ctrl #(
        .HEAP_DEPTH (HEAP_DEPTH),
        .AW         (AW),
        .CW         (CW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .op_valid    (s_tvalid),
        .op_ready    (s_tready),
        .op          (op),
        .op_entry    (op_entry),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr_a (mem_raddr_a),
        .mem_raddr_b (mem_raddr_b),
        .mem_rdata_a (mem_rdata_a),
        .mem_rdata_b (mem_rdata_b)
    );

    kwh_heap_mem #(
        .DEPTH (HEAP_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr_a (mem_raddr_a),
        .raddr_b (mem_raddr_b),
        .rdata_a (mem_rdata_a),
        .rdata_b (mem_rdata_b)
    );

    // The output register takes a new result whenever it is empty or its
    // current word leaves in the same cycle.
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        if (res_valid && res_ready)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {7'd0, res.occupancy, res.lane, res.value};
            m_tuser_next  = res.status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
